// ===== rtl/svv_pkg.sv =====
`timescale 1ns / 1ps

package svv_pkg;

  localparam int VolW     = 7;
  localparam int LevelW   = 14;
  localparam int ProdW    = 2 * LevelW;
  localparam int PanShift = 12;
  localparam int GainShift = 14;
  localparam int NumOps   = 7;
  localparam int Depth    = NumOps + 1;

  localparam logic [VolW-1:0] PanRightFrom = 7'h41;
  localparam logic [VolW-1:0] PanLeftBelow = 7'h3f;
  localparam logic [VolW-1:0] PanFull      = 7'h7f;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = VolW;

  localparam logic [CfgIdxW-1:0] CfgMono   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSfx    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaster = 2'd2;

  localparam logic [LevelW-1:0] FullGain = 14'd16129;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_PAN_LEFT,
    OP_PAN_RIGHT,
    OP_GAIN
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [LevelW-1:0] coef;
  } op_t;

  typedef struct packed {
    logic [LevelW-1:0]   left;
    logic [LevelW-1:0]   right;
    op_t  [NumOps-1:0]   ops;
  } word_t;

  typedef struct packed {
    logic [VolW-1:0] voice_level;
    logic [VolW-1:0] cmd_volume;
    logic [VolW-1:0] cmd_pan;
    logic [VolW-1:0] tone_volume;
    logic [VolW-1:0] tone_pan;
    logic [VolW-1:0] program_volume;
  } in_word_t;

  typedef struct packed {
    logic [LevelW-1:0] left_level;
    logic [LevelW-1:0] right_level;
  } out_word_t;

  function automatic logic [LevelW-1:0] sq7(logic [VolW-1:0] v);
    logic [LevelW-1:0] p;
    p = LevelW'(v) * LevelW'(v);
    return p;
  endfunction

endpackage

// ===== rtl/svv_stream_if.sv =====
`timescale 1ns / 1ps

interface svv_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/svv_prep.sv =====
`timescale 1ns / 1ps

module svv_prep import svv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mono_i,
  input  logic [LevelW-1:0] sfx_sq_i,
  input  logic [LevelW-1:0] master_sq_i,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  in_word_t          up_word_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output word_t             dn_word_o
);

  logic  valid_q;
  word_t word_q;
  word_t word_d;

  function automatic op_t pan_op(logic [VolW-1:0] pan, logic mono);
    op_t       op;
    logic [VolW-1:0] d;
    d = PanFull - pan;
    op.kind = OP_PASS;
    op.coef = sq7(pan);
    if (!mono) begin
      if (pan >= PanRightFrom) begin
        op.kind = OP_PAN_LEFT;
        op.coef = sq7(d);
      end else if (pan < PanLeftBelow) begin
        op.kind = OP_PAN_RIGHT;
      end
    end
    return op;
  endfunction

  assign up_ready_o = !valid_q || dn_ready_i;

  always_comb begin
    word_d.left  = sq7(up_word_i.voice_level);
    word_d.right = sq7(up_word_i.voice_level);
    word_d.ops[0] = pan_op(up_word_i.cmd_pan, mono_i);
    word_d.ops[1] = '{kind: OP_GAIN, coef: sq7(up_word_i.tone_volume)};
    word_d.ops[2] = pan_op(up_word_i.tone_pan, mono_i);
    word_d.ops[3] = '{kind: OP_GAIN, coef: sq7(up_word_i.cmd_volume)};
    word_d.ops[4] = '{kind: OP_GAIN, coef: sq7(up_word_i.program_volume)};
    word_d.ops[5] = '{kind: OP_GAIN, coef: sfx_sq_i};
    word_d.ops[6] = '{kind: OP_GAIN, coef: master_sq_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      word_q <= word_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_word_o  = word_q;

endmodule

// ===== rtl/svv_cell.sv =====
`timescale 1ns / 1ps

module svv_cell import svv_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  up_valid_i,
  output logic  up_ready_o,
  input  word_t up_word_i,
  output logic  dn_valid_o,
  input  logic  dn_ready_i,
  output word_t dn_word_o
);

  logic             valid_q;
  word_t            word_q;
  word_t            word_d;
  op_t              op;
  logic [ProdW-1:0] prod_l;
  logic [ProdW-1:0] prod_r;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign op         = up_word_i.ops[Idx];
  assign prod_l     = ProdW'(up_word_i.left) * ProdW'(op.coef);
  assign prod_r     = ProdW'(up_word_i.right) * ProdW'(op.coef);

  always_comb begin
    word_d = up_word_i;
    case (op.kind)
      OP_PAN_LEFT: begin
        word_d.left = prod_r[PanShift +: LevelW];
      end
      OP_PAN_RIGHT: begin
        word_d.right = prod_l[PanShift +: LevelW];
      end
      OP_GAIN: begin
        word_d.left  = prod_l[GainShift +: LevelW];
        word_d.right = prod_r[GainShift +: LevelW];
      end
      default: begin
        word_d = up_word_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      word_q <= word_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_word_o  = word_q;

endmodule

// ===== rtl/stereo_voice_volume_pan_law.sv =====
`timescale 1ns / 1ps

// channel   dir  payload                                        handshake
// in_i      in   voice_level cmd_volume cmd_pan tone_volume     valid/ready
//                tone_pan program_volume (7 bits each)
// out_o     out  left_level right_level (14 bits each)          valid/ready
// cfg       in   cfg_we_i cfg_idx_i cfg_data_i                  write only
//
// one word per cycle while in_i.ready is high; each word passes through the chain
// (prep stage plus seven cells, each cell one pair of 14x14 multiplies)
// reset clears the stage valid bits and loads mono off, sfx and master full
// a stall at out_o fills empty stages first; in_i.ready drops only when
// every stage holds a word

module stereo_voice_volume_pan_law import svv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  svv_stream_if.sink          in_i,
  svv_stream_if.source        out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic              mono_q;
  logic [LevelW-1:0] sfx_sq_q;
  logic [LevelW-1:0] master_sq_q;

  logic              valid_w [Depth];
  logic              ready_w [Depth];
  word_t             word_w  [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q      <= 1'b0;
      sfx_sq_q    <= FullGain;
      master_sq_q <= FullGain;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMono:   mono_q      <= cfg_data_i[0];
        CfgSfx:    sfx_sq_q    <= sq7(cfg_data_i);
        CfgMaster: master_sq_q <= sq7(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  svv_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mono_i      (mono_q),
    .sfx_sq_i    (sfx_sq_q),
    .master_sq_i (master_sq_q),
    .up_valid_i  (in_i.valid),
    .up_ready_o  (in_i.ready),
    .up_word_i   (in_i.data),
    .dn_valid_o  (valid_w[0]),
    .dn_ready_i  (ready_w[0]),
    .dn_word_o   (word_w[0])
  );

  for (genvar k = 0; k < NumOps; k++) begin : g_cell
    svv_cell #(
      .Idx (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (valid_w[k]),
      .up_ready_o (ready_w[k]),
      .up_word_i  (word_w[k]),
      .dn_valid_o (valid_w[k+1]),
      .dn_ready_i (ready_w[k+1]),
      .dn_word_o  (word_w[k+1])
    );
  end

  assign ready_w[NumOps]       = out_o.ready;
  assign out_o.valid           = valid_w[NumOps];
  assign out_o.data.left_level  = word_w[NumOps].left;
  assign out_o.data.right_level = word_w[NumOps].right;

endmodule

// ===== rtl/svv_checker.sv =====
`timescale 1ns / 1ps

module svv_checker import svv_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [LevelW-1:0] out_left_i,
  input logic [LevelW-1:0] out_right_i
);

  localparam int CntW = $clog2(Depth + 1);

  logic [CntW-1:0] count_q;
  logic            in_acc;
  logic            out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_q + CntW'(in_acc) - CntW'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_left_i)
      && $stable(out_right_i))
    else $error("result word changed while stalled");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output drains");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_q != '0)
    else $error("result word with no word in flight");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("more words in flight than stages");

endmodule

bind stereo_voice_volume_pan_law svv_checker u_svv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.data.left_level),
  .out_right_i (out_o.data.right_level)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import svv_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int HoldCycles = 300;
  localparam int IdleLimit = 4000;
  localparam logic [LevelW-1:0] FullLevel = 14'd14909;

  typedef struct {
    in_word_t  stim;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  typedef struct {
    bit mono;
    bit [VolW-1:0] sfx;
    bit [VolW-1:0] master;
    int count;
    bit calm;
    bit hold;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  svv_stream_if #(.T(in_word_t)) word_in ();
  svv_stream_if #(.T(out_word_t)) word_out ();

  bit mono_on = 1'b0;
  bit [VolW-1:0] sfx_gain = 7'd127;
  bit [VolW-1:0] master_gain = 7'd127;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  out_word_t expected_levels[$];

  dir_row_t dir_rows [15] = '{
    '{'{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0}, 1'b1, '{14'd0, 14'd0}},
    '{'{7'd127, 7'd127, 7'd63, 7'd127, 7'd63, 7'd127}, 1'b1, '{FullLevel, FullLevel}},
    '{'{7'd127, 7'd127, 7'd64, 7'd127, 7'd64, 7'd127}, 1'b1, '{FullLevel, FullLevel}},
    '{'{7'd127, 7'd127, 7'd0, 7'd127, 7'd63, 7'd127}, 1'b1, '{FullLevel, 14'd0}},
    '{'{7'd127, 7'd127, 7'd127, 7'd127, 7'd64, 7'd127}, 1'b1, '{14'd0, FullLevel}},
    '{'{7'd127, 7'd127, 7'd64, 7'd127, 7'd0, 7'd127}, 1'b1, '{FullLevel, 14'd0}},
    '{'{7'd127, 7'd127, 7'd63, 7'd127, 7'd127, 7'd127}, 1'b1, '{14'd0, FullLevel}},
    '{'{7'd127, 7'd127, 7'd127, 7'd0, 7'd63, 7'd127}, 1'b1, '{14'd0, 14'd0}},
    '{'{7'd127, 7'd0, 7'd63, 7'd127, 7'd63, 7'd127}, 1'b1, '{14'd0, 14'd0}},
    '{'{7'd127, 7'd127, 7'd63, 7'd127, 7'd63, 7'd0}, 1'b1, '{14'd0, 14'd0}},
    '{'{7'd127, 7'd127, 7'd65, 7'd127, 7'd62, 7'd127}, 1'b0, '{14'd0, 14'd0}},
    '{'{7'd127, 7'd127, 7'd62, 7'd127, 7'd65, 7'd127}, 1'b0, '{14'd0, 14'd0}},
    '{'{7'd100, 7'd90, 7'd1, 7'd80, 7'd126, 7'd70}, 1'b0, '{14'd0, 14'd0}},
    '{'{7'h55, 7'h2a, 7'h2a, 7'h55, 7'h55, 7'h2a}, 1'b0, '{14'd0, 14'd0}},
    '{'{7'h2a, 7'h55, 7'h55, 7'h2a, 7'h2a, 7'h55}, 1'b0, '{14'd0, 14'd0}}
  };

  stereo_voice_volume_pan_law dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (word_in),
    .out_o      (word_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic void pan_apply(input logic [VolW-1:0] pan,
                                    inout bit [31:0] lft, inout bit [31:0] rgt);
    bit [31:0] far;
    if (mono_on) return;
    if (pan >= PanRightFrom) begin
      far = 32'(PanFull - pan);
      lft = (rgt * far * far) >> PanShift;
    end else if (pan < PanLeftBelow) begin
      rgt = (lft * 32'(pan) * 32'(pan)) >> PanShift;
    end
  endfunction

  function automatic void gain_apply(input logic [VolW-1:0] vol,
                                     inout bit [31:0] lft, inout bit [31:0] rgt);
    bit [31:0] g;
    g = 32'(vol) * 32'(vol);
    lft = ((lft * g) >> GainShift) & 32'hffff;
    rgt = ((rgt * g) >> GainShift) & 32'hffff;
  endfunction

  function automatic out_word_t mix_levels(input in_word_t w);
    bit [31:0] lft;
    bit [31:0] rgt;
    out_word_t res;
    lft = 32'(w.voice_level) * 32'(w.voice_level);
    rgt = lft;
    pan_apply(w.cmd_pan, lft, rgt);
    gain_apply(w.tone_volume, lft, rgt);
    pan_apply(w.tone_pan, lft, rgt);
    gain_apply(w.cmd_volume, lft, rgt);
    gain_apply(w.program_volume, lft, rgt);
    gain_apply(sfx_gain, lft, rgt);
    gain_apply(master_gain, lft, rgt);
    res.left_level = lft[LevelW-1:0];
    res.right_level = rgt[LevelW-1:0];
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VolW-1:0] pick_volume();
    case ($urandom_range(0, 9))
      0: return 7'd127;
      1: return 7'd0;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [VolW-1:0] pick_pan();
    case ($urandom_range(0, 11))
      0: return 7'd63;
      1: return 7'd64;
      2: return 7'd0;
      3: return 7'd127;
      4: return 7'd65;
      5: return 7'd62;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int gap;
    word_in.valid <= 1'b1;
    word_in.data <= w;
    @(posedge clk_i);
    while (!word_in.ready) @(posedge clk_i);
    expected_levels.push_back(typed ? want : mix_levels(w));
    gap = gap_len();
    if (gap != 0) begin
      word_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    word_in.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_mix(input bit mono, input bit [VolW-1:0] sfx,
                         input bit [VolW-1:0] master);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgMono;
    cfg_data_i <= {6'($urandom), mono};
    @(posedge clk_i);
    cfg_idx_i <= CfgSfx;
    cfg_data_i <= sfx;
    @(posedge clk_i);
    cfg_idx_i <= CfgMaster;
    cfg_data_i <= master;
    @(posedge clk_i);
    cfg_idx_i <= CfgUnused;
    cfg_data_i <= 7'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mono_on = mono;
    sfx_gain = sfx;
    master_gain = master;
  endtask

  // receiver side
  initial begin
    word_out.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        word_out.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
        word_out.ready <= 1'b0;
        repeat (1 + gap_len()) @(posedge clk_i);
      end else begin
        word_out.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_levels
    out_word_t want;
    if (word_out.valid && word_out.ready) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected word: left_level %0d right_level %0d",
               word_out.data.left_level, word_out.data.right_level);
        mismatch_count++;
      end else begin
        want = expected_levels.pop_front();
        if (word_out.data.left_level !== want.left_level) begin
          $error("left_level expected %0d actual %0d",
                 want.left_level, word_out.data.left_level);
          mismatch_count++;
        end
        if (word_out.data.right_level !== want.right_level) begin
          $error("right_level expected %0d actual %0d",
                 want.right_level, word_out.data.right_level);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("stereo_voice_volume_pan_law test failed");
        $finish;
      end
    end
  end

  initial begin
    phase_t plan [8];
    in_word_t w;
    word_in.valid = 1'b0;
    word_in.data = '0;
    plan = '{
      '{1'b0, 7'd127, 7'd127, 120, 1'b0, 1'b0},
      '{1'b1, 7'd127, 7'd127, 100, 1'b1, 1'b0},
      '{1'b0, 7'd0, 7'd127, 25, 1'b0, 1'b0},
      '{1'b0, 7'd127, 7'd0, 25, 1'b0, 1'b0},
      '{1'b1, 7'd1, 7'd1, 60, 1'b0, 1'b0},
      '{1'b0, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 120, 1'b0, 1'b1},
      '{1'b1, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 100, 1'b0, 1'b0},
      '{1'b0, 7'd127, 7'd127, 150, 1'b0, 1'b0}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int walk = 0; walk < 2; walk++) begin
      if (walk == 1) begin
        drain();
        set_mix(1'b1, 7'd127, 7'd127);
      end
      foreach (dir_rows[i])
        send_word(dir_rows[i].stim, dir_rows[i].typed && walk == 0, dir_rows[i].want);
    end

    foreach (plan[p]) begin
      drain();
      set_mix(plan[p].mono, plan[p].sfx, plan[p].master);
      no_gaps = plan[p].calm;
      if (plan[p].hold) hold_req = 1'b1;
      for (int n = 0; n < plan[p].count; n++) begin
        w.voice_level = pick_volume();
        w.cmd_volume = pick_volume();
        w.cmd_pan = pick_pan();
        w.tone_volume = pick_volume();
        w.tone_pan = pick_pan();
        w.program_volume = pick_volume();
        send_word(w, 1'b0, '0);
      end
      no_gaps = 1'b0;
    end

    drain();
    repeat (4 * Depth) @(posedge clk_i);
    if (mismatch_count == 0 && expected_levels.size() == 0) begin
      $display("stereo_voice_volume_pan_law test passed");
    end else begin
      $display("stereo_voice_volume_pan_law test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/svv_pkg.sv
rtl/svv_stream_if.sv
rtl/svv_prep.sv
rtl/svv_cell.sv
rtl/stereo_voice_volume_pan_law.sv
rtl/svv_checker.sv
bench/testbench.sv
